FILE: rtl/ssrle_pkg.sv
// Shared types and constants of the sprite skip/run RLE decoder.
// No dependencies; every other source file except ssrle_ram imports this package.
package ssrle_pkg;

    localparam int MAX_WIDTH       = 32'h400;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    localparam int ROW_W   = 15;
    localparam int COL_W   = 11;
    localparam int LEN_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int RGB_W   = 24;
    localparam int COLOR_W = 32;
    localparam int WIDTH_W = 16;
    localparam int STAT_W  = 3;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef enum logic [CFG_AW-1:0] {
        REG_ROW_WIDTH = 2'd0,
        REG_ROW_COUNT = 2'd1,
        REG_MASK_MODE = 2'd2
    } t_reg_index;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_SIZE     = 3'd1,
        ST_SKIP_PAST    = 3'd2,
        ST_RUN_PAST     = 3'd3,
        ST_ROW_MISMATCH = 3'd4,
        ST_EARLY_END    = 3'd5,
        ST_TRAILING     = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_RUN  = 4'b0010,
        PH_LIT  = 4'b0100,
        PH_FIN  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [WIDTH_W-1:0] row_width;
        logic [ROW_W-1:0]   row_count;
        logic               mask_mode;
    } t_cfg;

    typedef struct packed {
        logic               have;
        logic               lit;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
        logic               done;
        t_status            status;
    } t_dec_res;

endpackage

FILE: rtl/ssrle_if.sv
// Valid/ready channel interfaces: configuration, input item and result item.
// Depends on ssrle_pkg for field widths.
interface ssrle_cfg_if import ssrle_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface ssrle_in_if import ssrle_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [PAL_AW-1:0] palette_index;
    logic [RGB_W-1:0]  palette_rgb;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output req_type, output palette_index, output palette_rgb,
                    output data_byte, output last_byte, input ready);
    modport sink   (input valid, input req_type, input palette_index, input palette_rgb,
                    input data_byte, input last_byte, output ready);
endinterface

interface ssrle_out_if import ssrle_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   span_row;
    logic [COL_W-1:0]   span_column;
    logic [LEN_W-1:0]   span_length;
    logic [COLOR_W-1:0] span_color;
    logic               done_res;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output span_row, output span_column, output span_length,
                    output span_color, output done_res, output status, input ready);
    modport sink   (input valid, input span_row, input span_column, input span_length,
                    input span_color, input done_res, input status, output ready);
endinterface

FILE: rtl/ssrle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ssrle_core.sv
// Row/column tracking and skip/run/literal decode of one payload byte per cycle in which i_step is high.
// Depends on ssrle_pkg.
module ssrle_core import ssrle_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  t_cfg              i_cfg,
    output t_dec_res          o_res
);

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_phase           r_phase, n_phase;
    logic [LEN_W-1:0] r_lits, n_lits;
    t_status          r_err, n_err;

    logic             bad_size;
    logic [COL_W:0]   col_sum;
    logic             past_width;
    logic [ROW_W:0]   row_inc;
    logic [LEN_W-1:0] lits_dec;

    assign bad_size   = (i_cfg.row_width == '0) ||
                        (i_cfg.row_width > WIDTH_W'(MAX_WIDTH)) ||
                        (i_cfg.row_count == '0);
    assign col_sum    = {1'b0, r_col} + {{(COL_W + 1 - BYTE_W){1'b0}}, i_data_byte};
    assign past_width = {{(WIDTH_W - COL_W - 1){1'b0}}, col_sum} > i_cfg.row_width;
    assign row_inc    = {1'b0, r_row} + {{ROW_W{1'b0}}, 1'b1};
    assign lits_dec   = r_lits - LEN_W'(1);

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_phase = r_phase;
        n_lits  = r_lits;
        n_err   = r_err;
        o_res   = '0;

        if (r_err == ST_OK) begin
            if (bad_size) begin
                n_err = ST_BAD_SIZE;
            end else begin
                unique case (r_phase)
                    PH_FIN: begin
                        n_err = ST_TRAILING;
                    end
                    PH_SKIP: begin
                        priority if (i_last_byte) begin
                            n_err = ST_EARLY_END;
                        end else if (past_width) begin
                            n_err = ST_SKIP_PAST;
                        end else begin
                            o_res.have = 1'b1;
                            o_res.row  = r_row;
                            o_res.col  = r_col;
                            o_res.len  = i_data_byte;
                            n_col      = col_sum[COL_W-1:0];
                            n_phase    = PH_RUN;
                        end
                    end
                    PH_RUN: begin
                        priority if (i_data_byte == '0) begin
                            if ({{(WIDTH_W - COL_W){1'b0}}, r_col} != i_cfg.row_width) begin
                                n_err = ST_ROW_MISMATCH;
                            end else begin
                                n_row = row_inc[ROW_W-1:0];
                                n_col = '0;
                                if (row_inc >= {1'b0, i_cfg.row_count}) begin
                                    n_phase = PH_FIN;
                                end else begin
                                    n_phase = PH_SKIP;
                                    if (i_last_byte) begin
                                        n_err = ST_EARLY_END;
                                    end
                                end
                            end
                        end else if (past_width) begin
                            n_err = ST_RUN_PAST;
                        end else if (i_last_byte) begin
                            n_err = ST_EARLY_END;
                        end else if (i_cfg.mask_mode) begin
                            o_res.have  = 1'b1;
                            o_res.row   = r_row;
                            o_res.col   = r_col;
                            o_res.len   = i_data_byte;
                            o_res.color = '1;
                            n_col       = col_sum[COL_W-1:0];
                            n_phase     = PH_SKIP;
                        end else begin
                            n_lits  = i_data_byte;
                            n_phase = PH_LIT;
                        end
                    end
                    PH_LIT: begin
                        if (i_last_byte) begin
                            n_err = ST_EARLY_END;
                        end else begin
                            o_res.have = 1'b1;
                            o_res.lit  = 1'b1;
                            o_res.row  = r_row;
                            o_res.col  = r_col;
                            o_res.len  = LEN_W'(1);
                            n_col      = r_col + COL_W'(1);
                            n_lits     = lits_dec;
                            if (lits_dec == '0) begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    default: begin
                        n_err = r_err;
                    end
                endcase
            end
        end

        if (i_last_byte) begin
            o_res        = '0;
            o_res.have   = 1'b1;
            o_res.done   = 1'b1;
            o_res.status = n_err;
            n_row        = '0;
            n_col        = '0;
            n_phase      = PH_SKIP;
            n_lits       = '0;
            n_err        = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_phase <= PH_SKIP;
            r_lits  <= '0;
            r_err   <= ST_OK;
        end else if (i_step) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_phase <= n_phase;
            r_lits  <= n_lits;
            r_err   <= n_err;
        end
    end

endmodule

FILE: rtl/sprite_skip_run_rle_decoder.sv
// Sprite skip/run RLE decoder top level: configuration registers, palette RAM,
// decode core and result register. Depends on ssrle_pkg, ssrle_if, ssrle_ram, ssrle_core.
//
// One input transaction (palette write or payload byte) is taken whenever it is ready; a
// byte's span or done result, if any, is in the result register the next cycle. The input
// is ready whenever the result register is empty or is being taken in the same cycle,
// so throughput is one item per cycle while the sink keeps up. A literal pixel's color
// comes from the 256-entry palette RAM through its registered read port, issued with
// the byte and held until the result is taken. The palette has no reset and needs no
// clearing pass; every entry must be written before a literal reads it. Configuration
// writes are always ready and must be made only while the block is idle.
module sprite_skip_run_rle_decoder import ssrle_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ssrle_cfg_if.sink    i_cfg,
    ssrle_in_if.sink     i_in,
    ssrle_out_if.source  o_out
);

    t_cfg               r_cfg;
    t_dec_res           dec_res;
    logic               in_accept;
    logic               step;
    logic               load;
    logic [RGB_W-1:0]   pal_rdata;

    logic               r_out_valid;
    logic               r_lit;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [LEN_W-1:0]   r_len;
    logic [COLOR_W-1:0] r_color;
    logic               r_done;
    logic [STAT_W-1:0]  r_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROW_WIDTH: r_cfg.row_width <= i_cfg.data;
                REG_ROW_COUNT: r_cfg.row_count <= i_cfg.data[ROW_W-1:0];
                REG_MASK_MODE: r_cfg.mask_mode <= i_cfg.data[0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;
    assign step       = in_accept && i_in.req_type;
    assign load       = step && dec_res.have;

    ssrle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .i_cfg       (r_cfg),
        .o_res       (dec_res)
    );

    ssrle_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (in_accept && !i_in.req_type),
        .i_waddr (i_in.palette_index),
        .i_wdata (i_in.palette_rgb),
        .i_re    (load && dec_res.lit),
        .i_raddr (i_in.data_byte),
        .o_rdata (pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lit    <= dec_res.lit;
            r_row    <= dec_res.row;
            r_col    <= dec_res.col;
            r_len    <= dec_res.len;
            r_color  <= dec_res.color;
            r_done   <= dec_res.done;
            r_status <= dec_res.status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.span_row    = r_row;
    assign o_out.span_column = r_col;
    assign o_out.span_length = r_len;
    assign o_out.span_color  = r_lit ? {ALPHA_OPAQUE, pal_rdata} : r_color;
    assign o_out.done_res    = r_done;
    assign o_out.status      = r_status;

endmodule

FILE: rtl/ssrle_checker.sv
// Port-level assertions of the sprite skip/run RLE decoder, bound to the top level.
// Depends on ssrle_pkg and sprite_skip_run_rle_decoder.
module ssrle_checker import ssrle_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ROW_W-1:0]   i_span_row,
    input logic [COL_W-1:0]   i_span_column,
    input logic [LEN_W-1:0]   i_span_length,
    input logic [COLOR_W-1:0] i_span_color,
    input logic               i_done_res,
    input logic [STAT_W-1:0]  i_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done_res |-> i_span_row == '0 && i_span_column == '0 &&
            i_span_length == '0 && i_span_color == '0)
        else $error("done result carries span fields");

    a_span_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res |-> i_status == ST_OK)
        else $error("span carries a status");

    a_span_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res && i_span_color != '0 |-> i_span_color[31:24] == ALPHA_OPAQUE)
        else $error("painted span is not opaque");

endmodule

bind sprite_skip_run_rle_decoder ssrle_checker u_ssrle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_span_row    (o_out.span_row),
    .i_span_column (o_out.span_column),
    .i_span_length (o_out.span_length),
    .i_span_color  (o_out.span_color),
    .i_done_res    (o_out.done_res),
    .i_status      (o_out.status)
);

FILE: tb/tb_sprite_skip_run_rle_decoder.sv
// Self-checking testbench for the sprite skip/run RLE decoder: directed sprites, error cases,
// register extremes and randomized traffic with source idling and sink back-pressure.
// Depends on ssrle_pkg, the ssrle_*_if interfaces and the sprite_skip_run_rle_decoder RTL.
module tb_sprite_skip_run_rle_decoder;
    import ssrle_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;

    typedef struct packed {
        logic               req_type;
        logic [PAL_AW-1:0]  pal_idx;
        logic [RGB_W-1:0]   rgb;
        logic [BYTE_W-1:0]  data;
        logic               last;
    } rle_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
        logic               done;
        t_status            status;
    } span_t;

    typedef logic [BYTE_W-1:0] byte_q_t [$];

    logic i_clk;
    logic i_rst_n;

    ssrle_cfg_if cfg_bus ();
    ssrle_in_if  in_bus ();
    ssrle_out_if out_bus ();

    sprite_skip_run_rle_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // decoder shadow state
    logic [RGB_W-1:0]   pal_model [PALETTE_ENTRIES];
    logic [WIDTH_W-1:0] cfg_width = '0;
    logic [ROW_W-1:0]   cfg_rows  = '0;
    logic               cfg_mask  = 1'b0;
    int                 dec_row   = 0;
    int                 dec_col   = 0;
    t_phase             dec_phase = PH_SKIP;
    logic [LEN_W-1:0]   dec_lits  = '0;
    t_status            dec_err   = ST_OK;

    span_t pending_spans [$];
    int    mismatches     = 0;
    int    cycle_count    = 0;
    int    bytes_sent     = 0;
    int    src_idle_pct   = 0;
    int    sink_stall_pct = 0;
    int    sink_hold      = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void decode_item(input rle_item_t it);
        int    nx;
        bit    have;
        span_t sp;
        if (!it.req_type) begin
            pal_model[it.pal_idx] = it.rgb;
            return;
        end
        have = 1'b0;
        sp = '0;
        if (dec_err == ST_OK) begin
            if (cfg_width == 0 || cfg_width > MAX_WIDTH || cfg_rows == 0) begin
                dec_err = ST_BAD_SIZE;
            end else begin
                case (dec_phase)
                    PH_FIN: dec_err = ST_TRAILING;
                    PH_SKIP: begin
                        nx = dec_col + int'(it.data);
                        if (it.last) begin
                            dec_err = ST_EARLY_END;
                        end else if (nx > int'(cfg_width)) begin
                            dec_err = ST_SKIP_PAST;
                        end else begin
                            have = 1'b1;
                            sp.row = dec_row[ROW_W-1:0];
                            sp.col = dec_col[COL_W-1:0];
                            sp.len = it.data;
                            dec_col = nx;
                            dec_phase = PH_RUN;
                        end
                    end
                    PH_RUN: begin
                        if (it.data == 0) begin
                            if (dec_col != int'(cfg_width)) begin
                                dec_err = ST_ROW_MISMATCH;
                            end else begin
                                dec_row++;
                                dec_col = 0;
                                dec_phase = (dec_row >= int'(cfg_rows)) ? PH_FIN : PH_SKIP;
                                if (it.last && dec_phase != PH_FIN) dec_err = ST_EARLY_END;
                            end
                        end else if (dec_col + int'(it.data) > int'(cfg_width)) begin
                            dec_err = ST_RUN_PAST;
                        end else if (it.last) begin
                            dec_err = ST_EARLY_END;
                        end else if (cfg_mask) begin
                            have = 1'b1;
                            sp.row = dec_row[ROW_W-1:0];
                            sp.col = dec_col[COL_W-1:0];
                            sp.len = it.data;
                            sp.color = '1;
                            dec_col += int'(it.data);
                            dec_phase = PH_SKIP;
                        end else begin
                            dec_lits = it.data;
                            dec_phase = PH_LIT;
                        end
                    end
                    default: begin
                        if (it.last) begin
                            dec_err = ST_EARLY_END;
                        end else begin
                            have = 1'b1;
                            sp.row = dec_row[ROW_W-1:0];
                            sp.col = dec_col[COL_W-1:0];
                            sp.len = 8'd1;
                            sp.color = {ALPHA_OPAQUE, pal_model[it.data]};
                            dec_col++;
                            dec_lits = dec_lits - 8'd1;
                            if (dec_lits == 0) dec_phase = PH_SKIP;
                        end
                    end
                endcase
            end
        end
        if (it.last) begin
            sp = '0;
            sp.done = 1'b1;
            sp.status = dec_err;
            pending_spans.push_back(sp);
            dec_row = 0;
            dec_col = 0;
            dec_phase = PH_SKIP;
            dec_lits = '0;
            dec_err = ST_OK;
        end else if (have) begin
            pending_spans.push_back(sp);
        end
    endfunction

    function automatic string span_text(input span_t s);
        return $sformatf("row=%0d col=%0d len=%0d color=%h done=%0d status=%0d",
                         s.row, s.col, s.len, s.color, s.done, s.status);
    endfunction

    always @(posedge i_clk) begin
        span_t got;
        span_t want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = {out_bus.span_row, out_bus.span_column, out_bus.span_length,
                   out_bus.span_color, out_bus.done_res, out_bus.status};
            if (pending_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t: unexpected result %s", $time, span_text(got));
            end else begin
                want = pending_spans.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result mismatch, expected %s", $time, span_text(want));
                        $display("%0t:                  actual   %s", $time, span_text(got));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            out_bus.ready = 1'b0;
            sink_hold--;
        end else begin
            out_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sprite_skip_run_rle_decoder: FAIL");
            $finish;
        end
    end

    task automatic send_item(input rle_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid         = 1'b1;
        in_bus.req_type      = it.req_type;
        in_bus.palette_index = it.pal_idx;
        in_bus.palette_rgb   = it.rgb;
        in_bus.data_byte     = it.data;
        in_bus.last_byte     = it.last;
        forever begin
            @(posedge i_clk);
            if (in_bus.ready) break;
        end
        decode_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_palette(input logic [PAL_AW-1:0] idx, input logic [RGB_W-1:0] rgb);
        rle_item_t it;
        it.req_type = 1'b0;
        it.pal_idx  = idx;
        it.rgb      = rgb;
        it.data     = 8'($urandom_range(255));
        it.last     = 1'($urandom_range(1));
        send_item(it);
    endtask

    task automatic send_stream(input byte_q_t q, input bit mix_pal);
        rle_item_t it;
        for (int i = 0; i < q.size(); i++) begin
            if (mix_pal && $urandom_range(19) == 0) begin
                send_palette(8'($urandom_range(255)), 24'($urandom));
            end
            it.req_type = 1'b1;
            it.pal_idx  = 8'($urandom_range(255));
            it.rgb      = 24'($urandom);
            it.data     = q[i];
            it.last     = (i == q.size() - 1);
            send_item(it);
            bytes_sent++;
        end
    endtask

    task automatic wait_idle();
        in_bus.valid = 1'b0;
        while (pending_spans.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [CFG_DW-1:0] val);
        wait_idle();
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        forever begin
            @(posedge i_clk);
            if (cfg_bus.ready) break;
        end
        case (idx)
            REG_ROW_WIDTH: cfg_width = val;
            REG_ROW_COUNT: cfg_rows  = val[ROW_W-1:0];
            default:       cfg_mask  = val[0];
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic configure(input int w, input int rows, input bit mask);
        write_reg(REG_ROW_WIDTH, 16'(w));
        write_reg(REG_ROW_COUNT, 16'(rows));
        write_reg(REG_MASK_MODE, {15'd0, mask});
    endtask

    // well-formed sprite for the current registers, optionally damaged; random bytes if they are invalid
    task automatic build_sprite(input bit broken, output byte_q_t q);
        int lim;
        int span;
        int col;
        q = {};
        if (cfg_width == 0 || cfg_width > MAX_WIDTH || cfg_rows == 0) begin
            repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(255)));
            return;
        end
        for (int r = 0; r < int'(cfg_rows); r++) begin
            col = 0;
            forever begin
                lim = int'(cfg_width) - col;
                if (lim > 255) lim = 255;
                span = ($urandom_range(3) == 0) ? 0 : $urandom_range(lim);
                q.push_back(span[7:0]);
                col += span;
                if (col == int'(cfg_width)) break;
                lim = int'(cfg_width) - col;
                if (lim > 255) lim = 255;
                span = $urandom_range(1, lim);
                q.push_back(span[7:0]);
                if (!cfg_mask) repeat (span) q.push_back(8'($urandom_range(255)));
                col += span;
            end
            q.push_back(8'd0);
        end
        if (broken) begin
            case ($urandom_range(2))
                0: if (q.size() > 1) repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
                1: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(255)));
                default: q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
            endcase
        end
    endtask

    task automatic pick_random_config();
        int  sel;
        int  w;
        int  rows;
        bit  mask;
        sel  = $urandom_range(19);
        mask = 1'($urandom_range(1));
        rows = $urandom_range(1, 3);
        w    = $urandom_range(1, 24);
        if (sel == 0) begin
            w = MAX_WIDTH;
            rows = 1;
            mask = 1'b1;
        end else if (sel == 1) begin
            w = $urandom_range(1) ? 0 : $urandom_range(MAX_WIDTH + 1, 65535);
        end else if (sel == 2) begin
            rows = 0;
        end
        configure(w, rows, mask);
    endtask

    task automatic test_palette_load();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_palette(8'd0, 24'h000000);
        for (int i = 1; i < PALETTE_ENTRIES - 1; i++) send_palette(8'(i), 24'($urandom));
        send_palette(8'd255, 24'hffffff);
    endtask

    task automatic test_basic_sprite();
        configure(4, 2, 1'b0);
        send_stream('{8'd0, 8'd2, 8'd0, 8'd255, 8'd2, 8'd0, 8'd4, 8'd0}, 1'b0);
    endtask

    task automatic test_error_cases();
        configure(4, 2, 1'b0);
        send_stream('{8'd5, 8'd0}, 1'b0);
        send_stream('{8'd1, 8'd4, 8'd0}, 1'b0);
        send_stream('{8'd1, 8'd0}, 1'b0);
        send_stream('{8'd0}, 1'b0);
        send_stream('{8'd0, 8'd1, 8'd7}, 1'b0);
        configure(1, 1, 1'b0);
        send_stream('{8'd1, 8'd0, 8'd9}, 1'b0);
    endtask

    task automatic test_mask_mode();
        configure(4, 1, 1'b1);
        send_stream('{8'd1, 8'd3, 8'd0, 8'd0}, 1'b0);
    endtask

    task automatic test_size_extremes();
        byte_q_t q;
        configure(0, 1, 1'b0);
        send_stream('{8'd0}, 1'b0);
        write_reg(REG_ROW_WIDTH, 16'hffff);
        send_stream('{8'd3}, 1'b0);
        write_reg(REG_ROW_WIDTH, 16'(MAX_WIDTH + 1));
        send_stream('{8'd0, 8'd0}, 1'b0);
        configure(4, 0, 1'b0);
        send_stream('{8'd0}, 1'b0);
        configure(1, 32767, 1'b1);
        send_stream('{8'd1, 8'd0, 8'd0, 8'd1, 8'd0}, 1'b0);
        configure(MAX_WIDTH, 2, 1'b1);
        build_sprite(1'b0, q);
        send_stream(q, 1'b0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_bytes);
        byte_q_t q;
        int      stop;
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            if ($urandom_range(99) < 35) pick_random_config();
            build_sprite($urandom_range(99) < 20, q);
            send_stream(q, 1'b1);
        end
    endtask

    task automatic test_backpressure();
        byte_q_t q;
        configure(16, 2, 1'b0);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = 300;
        build_sprite(1'b0, q);
        send_stream(q, 1'b0);
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_ROW_WIDTH;
        cfg_bus.data          = '0;
        in_bus.valid          = 1'b0;
        in_bus.req_type       = 1'b0;
        in_bus.palette_index  = '0;
        in_bus.palette_rgb    = '0;
        in_bus.data_byte      = '0;
        in_bus.last_byte      = 1'b0;
        out_bus.ready         = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_palette_load();
        test_basic_sprite();
        test_error_cases();
        test_mask_mode();
        test_size_extremes();
        test_random_traffic(0, 0, 110);
        test_random_traffic(83, 0, 110);
        test_random_traffic(0, 83, 110);
        test_random_traffic(8, 8, 110);
        test_backpressure();
        wait_idle();

        if (mismatches == 0 && pending_spans.size() == 0) begin
            $display("tb_sprite_skip_run_rle_decoder: PASS");
        end else begin
            $display("tb_sprite_skip_run_rle_decoder: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ssrle_pkg.sv
rtl/ssrle_if.sv
rtl/ssrle_ram.sv
rtl/ssrle_core.sv
rtl/sprite_skip_run_rle_decoder.sv
rtl/ssrle_checker.sv
tb/tb_sprite_skip_run_rle_decoder.sv
